@@ design/cvp_pkg.sv @@
package cvp_pkg;

    localparam int OUT_WIDTH_DEF  = 32;
    localparam int STORE_ROWS_DEF = 4;

    localparam int PX_W   = 8;
    localparam int RESP_W = 12;   // responses stay within +-2040
    localparam int POOL_W = 11;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    // 3x3 kernels per channel, row by row
    localparam logic signed [2:0] KERN [3][3][3] = '{
        '{'{3'sd0, 3'sd1, 3'sd2}, '{-3'sd1, 3'sd0, 3'sd1}, '{-3'sd2, -3'sd1, 3'sd0}},
        '{'{-3'sd1, -3'sd2, -3'sd1}, '{3'sd0, 3'sd0, 3'sd0}, '{3'sd1, 3'sd2, 3'sd1}},
        '{'{-3'sd1, 3'sd0, 3'sd1}, '{-3'sd2, 3'sd0, 3'sd2}, '{-3'sd1, 3'sd0, 3'sd1}}
    };

    // four window rows by three columns of one channel
    typedef logic [3:0][2:0][PX_W-1:0] t_win;
    typedef logic signed [RESP_W-1:0]  t_resp;
    typedef logic [POOL_W-1:0]         t_pool;

    typedef struct packed {
        logic vld;    // stage holds a column
        logic first;  // left column even: start of an output column
        logic emit;   // left column odd: output column complete
        logic fin;    // last input column of the sweep
    } t_ctl;

endpackage

@@ design/cvp_pix_if.sv @@
interface cvp_pix_if;
    logic                      valid;
    logic                      ready;
    logic [cvp_pkg::PX_W-1:0]  pixel_blue;
    logic [cvp_pkg::PX_W-1:0]  pixel_green;
    logic [cvp_pkg::PX_W-1:0]  pixel_red;

    modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
    modport sink   (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

@@ design/cvp_pool_if.sv @@
interface cvp_pool_if;
    logic                        valid;
    logic                        ready;
    logic [cvp_pkg::POOL_W-1:0]  pool_blue;
    logic [cvp_pkg::POOL_W-1:0]  pool_green;
    logic [cvp_pkg::POOL_W-1:0]  pool_red;
    logic                        last_of_band;

    modport source (output valid, pool_blue, pool_green, pool_red, last_of_band,
                    input ready);
    modport sink   (input valid, pool_blue, pool_green, pool_red, last_of_band,
                    output ready);
endinterface

@@ design/cvp_lane.sv @@
// One channel: responses of both row windows at the current left column.
module cvp_lane #(
    parameter int CH = cvp_pkg::CH_BLUE
) (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  cvp_pkg::t_win        i_win,
    output cvp_pkg::t_resp       o_resp [2]
);

    cvp_pkg::t_resp n_resp [2];
    cvp_pkg::t_resp r_resp [2];

    always_comb begin
        for (int w = 0; w < 2; w++) begin
            n_resp[w] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    n_resp[w] = n_resp[w]
                        + cvp_pkg::RESP_W'(signed'({1'b0, i_win[w+r][c]}))
                        * cvp_pkg::RESP_W'(cvp_pkg::KERN[CH][r][c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_resp[0] <= n_resp[0];
            r_resp[1] <= n_resp[1];
        end
    end

    assign o_resp = r_resp;

endmodule

@@ design/cvp_merge.sv @@
// Merges lane responses: rectify, 2x2 max, output register, closing zero column.
module cvp_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  cvp_pkg::t_ctl     i_ctl,
    input  cvp_pkg::t_resp    i_resp [3][2],
    output logic              o_busy,
    cvp_pool_if.source        o_pool
);

    cvp_pkg::t_pool r_best [3];
    cvp_pkg::t_pool n_clip [3];
    cvp_pkg::t_pool n_out  [3];
    cvp_pkg::t_pool r_out  [3];
    logic           r_valid;
    logic           r_last;
    logic           r_pend;

    always_comb begin
        cvp_pkg::t_resp mx;
        for (int ch = 0; ch < 3; ch++) begin
            mx = (i_resp[ch][1] > i_resp[ch][0]) ? i_resp[ch][1] : i_resp[ch][0];
            n_clip[ch] = mx[cvp_pkg::RESP_W-1] ? '0 : mx[cvp_pkg::POOL_W-1:0];
            n_out[ch]  = (n_clip[ch] > r_best[ch]) ? n_clip[ch] : r_best[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_adv) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_last  <= 1'b1;
                r_pend  <= 1'b0;
                for (int ch = 0; ch < 3; ch++) r_out[ch] <= '0;
            end else if (i_ctl.vld && i_ctl.emit) begin
                r_valid <= 1'b1;
                r_last  <= 1'b0;
                r_pend  <= i_ctl.fin;
                r_out   <= n_out;
            end else begin
                r_valid <= 1'b0;
            end
            if (i_ctl.vld && i_ctl.first) begin
                r_best <= n_clip;
            end
        end
    end

    assign o_busy              = r_pend;
    assign o_pool.valid        = r_valid;
    assign o_pool.pool_blue    = r_out[cvp_pkg::CH_BLUE];
    assign o_pool.pool_green   = r_out[cvp_pkg::CH_GREEN];
    assign o_pool.pool_red     = r_out[cvp_pkg::CH_RED];
    assign o_pool.last_of_band = r_last;

endmodule

@@ design/conv3x3_relu_maxpool2x2.sv @@
// 3x3 convolution, rectification and 2x2 max pooling on a BGR pixel stream.
//
// i_pix  : sink; one pixel per transaction in raster order, lines of
//          2*OUT_WIDTH pixels. Pixels go into a ring line store of
//          STORE_ROWS rows, one memory bank per row.
// o_pool : source; after every second completed line, OUT_WIDTH transactions,
//          one per output column; the last is all zero with last_of_band set.
// Timing : a pixel is taken in any cycle with i_pix.valid and i_pix.ready high.
//          After the line that closes a band the block sweeps the 2*OUT_WIDTH
//          store columns, one per cycle while o_pool is not stalled, all bank
//          ports read in parallel; the results follow in column order and the
//          zero column comes after the last. A band is 4*OUT_WIDTH pixels;
//          i_pix.ready is low from the start of its sweep until the zero
//          column is out.
// Stall  : o_pool is registered; while it is held by the receiver the whole
//          sweep pipeline freezes, nothing is lost.
// Reset  : synchronous, active low. Row valid bits make the store read as
//          zero until a row is written; no clearing pass.
module conv3x3_relu_maxpool2x2 #(
    parameter int OUT_WIDTH  = cvp_pkg::OUT_WIDTH_DEF,
    parameter int STORE_ROWS = cvp_pkg::STORE_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cvp_pix_if.sink     i_pix,
    cvp_pool_if.source  o_pool
);

    localparam int LINE_WIDTH = 2 * OUT_WIDTH;
    localparam int CW = $clog2(LINE_WIDTH);
    localparam int RW = $clog2(STORE_ROWS);
    localparam int DW = 3 * cvp_pkg::PX_W;

    // write side
    logic [CW-1:0]         r_wcol;
    logic [RW-1:0]         r_wrow;
    logic                  r_second;
    logic [RW-1:0]         r_top;
    logic [STORE_ROWS-1:0] r_rowv;
    logic                  w_acc;
    logic                  w_eol;

    // sweep pipeline
    logic                  r_sweep;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_rsel [4];
    logic                  r_s1v;
    logic [CW-1:0]         r_s1col;
    logic                  r_s2v;
    logic [CW-1:0]         r_s2col;
    cvp_pkg::t_ctl         r_s3;
    cvp_pkg::t_ctl         n_s2ctl;
    logic [DW-1:0]         r_rd  [STORE_ROWS];
    logic [DW-1:0]         r_win [4][3];
    logic [DW-1:0]         n_new [4];
    cvp_pkg::t_win         w_lwin [3];
    cvp_pkg::t_resp        w_resp [3][2];
    logic                  w_adv;
    logic                  w_busy;

    assign w_adv       = !o_pool.valid || o_pool.ready;
    assign i_pix.ready = !r_sweep && !r_s1v && !r_s2v && !r_s3.vld && !w_busy;
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_eol       = (r_wcol == CW'(LINE_WIDTH - 1));

    function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a, input int k);
        logic [RW:0] s;
        s = {1'b0, a} + (RW+1)'(k);
        if (s >= (RW+1)'(STORE_ROWS)) s = s - (RW+1)'(STORE_ROWS);
        return s[RW-1:0];
    endfunction

    // line store banks, one per ring row
    for (genvar b = 0; b < STORE_ROWS; b++) begin : g_bank
        logic [DW-1:0] r_mem [LINE_WIDTH];
        always_ff @(posedge i_clk) begin
            if (w_acc && r_wrow == RW'(b)) begin
                r_mem[r_wcol] <= {i_pix.pixel_red, i_pix.pixel_green, i_pix.pixel_blue};
            end
            if (w_adv && r_sweep) begin
                r_rd[b] <= r_mem[r_col];
            end
        end
    end

    // write pointers and band start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcol   <= '0;
            r_wrow   <= '0;
            r_second <= 1'b0;
            r_top    <= RW'(STORE_ROWS - 2);
            r_rowv   <= '0;
            r_sweep  <= 1'b0;
            r_col    <= '0;
        end else begin
            if (w_acc) begin
                if (w_eol) begin
                    r_wcol         <= '0;
                    r_wrow         <= ring_add(r_wrow, 1);
                    r_rowv[r_wrow] <= 1'b1;
                    r_second       <= !r_second;
                    if (r_second) begin
                        r_sweep <= 1'b1;
                        r_col   <= '0;
                        for (int k = 0; k < 4; k++) r_rsel[k] <= ring_add(r_top, k);
                        r_top   <= ring_add(r_top, 2);
                    end
                end else begin
                    r_wcol <= r_wcol + 1'b1;
                end
            end
            if (w_adv && r_sweep) begin
                if (r_col == CW'(LINE_WIDTH - 1)) r_sweep <= 1'b0;
                else r_col <= r_col + 1'b1;
            end
        end
    end

    // window rows picked from banks; unwritten rows read as zero
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_new[k] = r_rowv[r_rsel[k]] ? r_rd[r_rsel[k]] : '0;
        end
        n_s2ctl.vld   = r_s2v;
        n_s2ctl.first = !r_s2col[0] && (r_s2col >= CW'(2));
        n_s2ctl.emit  = r_s2col[0] && (r_s2col >= CW'(3));
        n_s2ctl.fin   = (r_s2col == CW'(LINE_WIDTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_s3  <= '0;
        end else if (w_adv) begin
            r_s1v <= r_sweep;
            r_s2v <= r_s1v;
            r_s3  <= n_s2ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1col <= r_col;
            if (r_s1v) begin
                r_s2col <= r_s1col;
                for (int k = 0; k < 4; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                    r_win[k][2] <= n_new[k];
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    w_lwin[ch][k][c] = r_win[k][c][ch*cvp_pkg::PX_W +: cvp_pkg::PX_W];
                end
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        cvp_lane #(.CH(ch)) u_lane (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_win  (w_lwin[ch]),
            .o_resp (w_resp[ch])
        );
    end

    cvp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (r_s3),
        .i_resp  (w_resp),
        .o_busy  (w_busy),
        .o_pool  (o_pool)
    );

endmodule

@@ sim/conv3x3_relu_maxpool2x2_tb.sv @@
module conv3x3_relu_maxpool2x2_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = cvp_pkg::OUT_WIDTH_DEF;
    localparam int LW = 2 * OW;
    localparam int SR = cvp_pkg::STORE_ROWS_DEF;
    localparam int ROWS_TOTAL = 5;    // two full bands and one trailing line, 320 items
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [cvp_pkg::POOL_W-1:0] blue;
        logic [cvp_pkg::POOL_W-1:0] green;
        logic [cvp_pkg::POOL_W-1:0] red;
        logic                       last;
    } t_pooled;

    // Own copy of the block's filtering: ring store, band tracking, pooled outputs.
    class pool_scoreboard;
        int         kern_c [3][3][3];
        logic [7:0] rows [3][SR][LW];
        int         wr_row, wr_col, top_row;
        bit         second;
        t_pooled    pending [$];
        int         errors;

        function void reset_state();
            kern_c = '{'{'{0, 1, 2}, '{-1, 0, 1}, '{-2, -1, 0}},
                       '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}},
                       '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}}};
            foreach (rows[a, b, c]) rows[a][b][c] = '0;
            wr_row = 0; wr_col = 0; second = 0; top_row = SR - 2;
            pending.delete(); errors = 0;
        endfunction

        function int response(int ch, int top, int left);
            int acc;
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    if (left + c < LW)
                        acc += kern_c[ch][r][c] * int'(rows[ch][(top + r) % SR][left + c]);
            return acc;
        endfunction

        function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int      best [3];
            t_pooled res;
            rows[cvp_pkg::CH_BLUE][wr_row][wr_col]  = b;
            rows[cvp_pkg::CH_GREEN][wr_row][wr_col] = g;
            rows[cvp_pkg::CH_RED][wr_row][wr_col]   = r;
            wr_col++;
            if (wr_col < LW) return;
            wr_col = 0;
            wr_row = (wr_row + 1) % SR;
            if (!second) begin
                second = 1;
                return;
            end
            second = 0;
            for (int oc = 0; oc < OW; oc++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    best[ch] = 0;
                    if (oc + 1 < OW)
                        for (int w = 0; w < 2; w++)
                            for (int k = 0; k < 2; k++)
                                if (response(ch, top_row + w, 2 * oc + k) > best[ch])
                                    best[ch] = response(ch, top_row + w, 2 * oc + k);
                end
                res.blue  = best[0][cvp_pkg::POOL_W-1:0];
                res.green = best[1][cvp_pkg::POOL_W-1:0];
                res.red   = best[2][cvp_pkg::POOL_W-1:0];
                res.last  = (oc + 1 == OW);
                pending.push_back(res);
            end
            top_row = (top_row + 2) % SR;
        endfunction

        function void check_result(t_pooled got);
            t_pooled exp;
            if (pending.size() == 0) begin
                $error("unexpected pool transaction");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.blue !== exp.blue) begin
                $error("pool_blue exp %0d got %0d", exp.blue, got.blue); errors++;
            end
            if (got.green !== exp.green) begin
                $error("pool_green exp %0d got %0d", exp.green, got.green); errors++;
            end
            if (got.red !== exp.red) begin
                $error("pool_red exp %0d got %0d", exp.red, got.red); errors++;
            end
            if (got.last !== exp.last) begin
                $error("last_of_band exp %0d got %0d", exp.last, got.last); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #5 i_clk = ~i_clk;

    cvp_pix_if  pix_ch ();
    cvp_pool_if pool_ch ();

    conv3x3_relu_maxpool2x2 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_pool  (pool_ch.source)
    );

    pool_scoreboard sb = new();
    bit  src_done = 0;
    bit  hold_done = 0;
    int  idle_cycles = 0;

    initial begin
        pix_ch.valid = 0;
        pix_ch.pixel_blue = '0;
        pix_ch.pixel_green = '0;
        pix_ch.pixel_red = '0;
        pool_ch.ready = 0;
        sb.reset_state();
    end

    // Pixel content by row: first band extremes, second band a ramp and a two-colour pattern, then random.
    function automatic logic [23:0] pick_pixel(int row, int col);
        case (row)
            0: return (col % 2) ? 24'hFFFFFF : 24'h000000;
            1: return (col < OW) ? 24'hFFFFFF : 24'h000000;
            2: return {8'(col * 4), 8'(255 - col * 4), 8'(col * 4)};
            3: return (row + col) % 3 == 0 ? 24'hFF00FF : 24'h00FF00;
            default: begin
                if ($urandom_range(0, 3) == 0)
                    return {24{$urandom_range(0, 1) == 1'b1}};
                return 24'($urandom);
            end
        endcase
    endfunction

    task automatic send_pixel(logic [23:0] p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0 && $urandom_range(0, 2) == 0) gap = 0;
        if (gap > 0) begin
            pix_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid       <= 1;
        pix_ch.pixel_blue  <= p[23:16];
        pix_ch.pixel_green <= p[15:8];
        pix_ch.pixel_red   <= p[7:0];
        do @(posedge i_clk); while (!pix_ch.ready);
        sb.note_pixel(p[23:16], p[15:8], p[7:0]);
    endtask

    // Sender: valid is only lowered after acceptance, before an idle gap or at the end.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int r = 0; r < ROWS_TOTAL; r++)
            for (int c = 0; c < LW; c++)
                send_pixel(pick_pixel(r, c));
        pix_ch.valid <= 0;
        src_done = 1;
    end

    // Receiver: random stalls, plus one long hold-off just after the first result of the first band.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && sb.pending.size() == OW - 1) begin
                hold_done = 1;
                pool_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                pool_ch.ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            pool_ch.ready <= 1;
            do @(posedge i_clk); while (!pool_ch.valid);
            sb.check_result({pool_ch.pool_blue, pool_ch.pool_green, pool_ch.pool_red,
                             pool_ch.last_of_band});
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (pool_ch.valid && pool_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("conv3x3_relu_maxpool2x2_tb: FAIL");
            $finish;
        end
    end

    // End of run: all pixels in, all expected results received, then drain time.
    initial begin
        wait (src_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6 * OW + 50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("conv3x3_relu_maxpool2x2_tb: PASS");
        else
            $display("conv3x3_relu_maxpool2x2_tb: FAIL");
        $finish;
    end
endmodule
